// ----- hdl/tlv_credential_stream_parser_top_macros.svh -----
// ---------------------------------------------------------------------------
// tlv credential stream parser assertion macros
// concurrent check wrappers, compiled out when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef TLV_CREDENTIAL_STREAM_PARSER_TOP_MACROS_SVH
`define TLV_CREDENTIAL_STREAM_PARSER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TLVCSP_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlvcsp same-cycle check failed");
// next-cycle implication
`define TLVCSP_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlvcsp next-cycle check failed");
`else
`define TLVCSP_ASSERT_IMP(name, clk, rst, ante, cons)
`define TLVCSP_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/tlvcsp_pkg.sv -----
// ---------------------------------------------------------------------------
// tlvcsp_pkg
// shared widths, codes and result types of the credential stream parser
// ---------------------------------------------------------------------------
package tlvcsp_pkg;

  localparam int LEN_BITS          = 32;
  localparam int CAVEAT_COUNT_BITS = 16;
  localparam int VARINT_BITS       = 7;
  localparam int MAX_BYTES         = (LEN_BITS + VARINT_BITS - 1) / VARINT_BITS;
  localparam int SHIFT_W           = $clog2(MAX_BYTES);
  localparam int POS_W             = $clog2(LEN_BITS + VARINT_BITS);
  localparam int WIDE_W            = LEN_BITS + VARINT_BITS;

  // grammar bytes
  localparam logic [7:0] VERSION_BYTE   = 8'd2;
  localparam logic [7:0] TAG_LOCATION   = 8'd1;
  localparam logic [7:0] TAG_IDENTIFIER = 8'd2;
  localparam logic [7:0] TAG_VERIFIER   = 8'd4;
  localparam logic [7:0] TAG_SIGNATURE  = 8'd6;
  localparam logic [7:0] SECTION_END    = 8'd0;

  typedef enum logic [2:0] {
    ROLE_VERSION     = 3'd0,
    ROLE_TAG         = 3'd1,
    ROLE_LENGTH      = 3'd2,
    ROLE_PAYLOAD     = 3'd3,
    ROLE_SECTION_END = 3'd4,
    ROLE_TRAILING    = 3'd5,
    ROLE_IGNORED     = 3'd6
  } role_t;

  typedef enum logic [1:0] {
    FK_LOCATION   = 2'd0,
    FK_IDENTIFIER = 2'd1,
    FK_VERIFIER   = 2'd2,
    FK_SIGNATURE  = 2'd3
  } field_kind_t;

  typedef enum logic [1:0] {
    SEC_HEADER    = 2'd0,
    SEC_CAVEATS   = 2'd1,
    SEC_SIGNATURE = 2'd2
  } section_t;

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef struct packed {
    role_t                        byte_role;
    field_kind_t                  field_kind;
    section_t                     section;
    logic [CAVEAT_COUNT_BITS-1:0] caveat_index;
    logic [LEN_BITS-1:0]          field_length;
    logic [LEN_BITS-1:0]          payload_offset;
    logic [7:0]                   data_out;
    status_t                      status;
    logic                         message_end;
  } result_t;

endpackage

// ----- hdl/tlvcsp_ifs.sv -----
// ---------------------------------------------------------------------------
// tlvcsp channel interfaces
// valid/ready byte input channel and per-byte result channel
// ---------------------------------------------------------------------------
interface tlvcsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface tlvcsp_out_if;
  import tlvcsp_pkg::*;

  logic                         valid;
  logic                         ready;
  role_t                        byte_role;
  field_kind_t                  field_kind;
  section_t                     section;
  logic [CAVEAT_COUNT_BITS-1:0] caveat_index;
  logic [LEN_BITS-1:0]          field_length;
  logic [LEN_BITS-1:0]          payload_offset;
  logic [7:0]                   data_out;
  status_t                      status;
  logic                         message_end;

  modport source (output valid, byte_role, field_kind, section, caveat_index,
                  field_length, payload_offset, data_out, status, message_end,
                  input ready);
  modport sink (input valid, byte_role, field_kind, section, caveat_index,
                field_length, payload_offset, data_out, status, message_end,
                output ready);
endinterface

// ----- hdl/tlv_credential_stream_parser_top.sv -----
// ---------------------------------------------------------------------------
// tlv_credential_stream_parser_top
// byte-serial grammar checker for a tag-length-value credential stream
// ---------------------------------------------------------------------------
//
//  channel     | direction | transaction
//  ------------+-----------+-------------------------------------------------
//  byte_in     | sink      | one message byte plus end-of-message mark
//  result_out  | source    | role, field, section, offsets, status per byte
//
// one byte per cycle sustained while the skid entry is free; each result is
// registered in the output register, or in the skid entry while that is held
// the grammar state and the result register both update in the accepting
// cycle, so the only loop is the next-state logic
// a two-entry output stage (register plus skid) keeps byte_in ready for one
// more transaction while a result waits; byte_in stalls only when both hold
// rst is synchronous and active high; it empties the output stage and puts
// the grammar back to expecting a version byte
`include "tlv_credential_stream_parser_top_macros.svh"

module tlv_credential_stream_parser_top (
  input  logic        clk,
  input  logic        rst,
  tlvcsp_in_if.sink   byte_in,
  tlvcsp_out_if.source result_out
);
  import tlvcsp_pkg::*;

  // grammar position, one-hot
  typedef enum logic [11:0] {
    PH_VER         = 12'b0000_0000_0001,
    PH_HDR_FIRST   = 12'b0000_0000_0010,
    PH_HDR_ID      = 12'b0000_0000_0100,
    PH_HDR_EOS     = 12'b0000_0000_1000,
    PH_CAV_FIRST   = 12'b0000_0001_0000,
    PH_CAV_ID      = 12'b0000_0010_0000,
    PH_CAV_VID_EOS = 12'b0000_0100_0000,
    PH_CAV_EOS     = 12'b0000_1000_0000,
    PH_SIG_TAG     = 12'b0001_0000_0000,
    PH_LEN         = 12'b0010_0000_0000,
    PH_PAY         = 12'b0100_0000_0000,
    PH_DONE        = 12'b1000_0000_0000
  } phase_t;

  localparam logic [CAVEAT_COUNT_BITS-1:0] CAV_MAX = '1;
  localparam logic [SHIFT_W-1:0] LAST_SHIFT = SHIFT_W'(MAX_BYTES - 1);

  // grammar state
  phase_t                       phase, phase_next;
  field_kind_t                  cur_field, cur_field_next;
  section_t                     cur_section, cur_section_next;
  logic [LEN_BITS-1:0]          len_acc, len_acc_next;
  logic [SHIFT_W-1:0]           vshift, vshift_next;
  logic [LEN_BITS-1:0]          remaining, remaining_next;
  logic [CAVEAT_COUNT_BITS-1:0] cav_cnt, cav_cnt_next;
  logic                         error_flag, error_next;
  logic                         done_flag, done_next;

  // output stage
  result_t out_q, skid_q, res_next;
  logic    out_valid, skid_valid;
  logic    accept, out_fire;

  // per-byte working signals
  logic [7:0]          b;
  logic                last;
  role_t               role;
  field_kind_t         kind;
  logic [LEN_BITS-1:0] flen, off;
  logic                start;
  field_kind_t         start_kind;
  logic                fdone;
  logic [POS_W-1:0]    len_pos;
  logic [WIDE_W-1:0]   len_wide;
  logic                len_ovf;
  logic [LEN_BITS-1:0] acc_or;
  status_t             st;

  assign b    = byte_in.data_byte;
  assign last = byte_in.last_byte;

  // varint digit placed at its bit position; bits beyond the length width
  // flag an oversized length
  assign len_pos  = POS_W'(vshift) * POS_W'(VARINT_BITS);
  assign len_wide = WIDE_W'(b[VARINT_BITS-1:0]) << len_pos;
  assign len_ovf  = |len_wide[WIDE_W-1:LEN_BITS];
  assign acc_or   = len_acc | len_wide[LEN_BITS-1:0];

  always_comb begin
    phase_next       = phase;
    cur_field_next   = cur_field;
    cur_section_next = cur_section;
    len_acc_next     = len_acc;
    vshift_next      = vshift;
    remaining_next   = remaining;
    cav_cnt_next     = cav_cnt;
    error_next       = error_flag;
    done_next        = done_flag;
    role             = ROLE_VERSION;
    kind             = FK_LOCATION;
    flen             = '0;
    off              = '0;
    start            = 1'b0;
    start_kind       = FK_LOCATION;
    fdone            = 1'b0;

    if (error_flag) begin
      role = ROLE_IGNORED;
    end else if (done_flag) begin
      role = ROLE_TRAILING;
    end else begin
      unique case (phase)
        PH_VER: begin
          role = ROLE_VERSION;
          if (b == VERSION_BYTE) phase_next = PH_HDR_FIRST;
          else error_next = 1'b1;
        end
        PH_HDR_FIRST: begin
          role = ROLE_TAG;
          if (b == TAG_LOCATION) begin
            start = 1'b1; start_kind = FK_LOCATION;
          end else if (b == TAG_IDENTIFIER) begin
            start = 1'b1; start_kind = FK_IDENTIFIER;
          end else begin
            error_next = 1'b1;
          end
        end
        PH_HDR_ID, PH_CAV_ID: begin
          role = ROLE_TAG;
          if (b == TAG_IDENTIFIER) begin
            start = 1'b1; start_kind = FK_IDENTIFIER;
          end else begin
            error_next = 1'b1;
          end
        end
        PH_HDR_EOS: begin
          role = ROLE_SECTION_END;
          if (b == SECTION_END) begin
            cur_section_next = SEC_CAVEATS;
            phase_next       = PH_CAV_FIRST;
          end else begin
            error_next = 1'b1;
          end
        end
        PH_CAV_FIRST: begin
          if (b == SECTION_END) begin
            role             = ROLE_SECTION_END;
            cur_section_next = SEC_SIGNATURE;
            phase_next       = PH_SIG_TAG;
          end else begin
            role = ROLE_TAG;
            if (b == TAG_LOCATION) begin
              start = 1'b1; start_kind = FK_LOCATION;
            end else if (b == TAG_IDENTIFIER) begin
              start = 1'b1; start_kind = FK_IDENTIFIER;
            end else begin
              error_next = 1'b1;
            end
          end
        end
        PH_CAV_VID_EOS, PH_CAV_EOS: begin
          if (phase == PH_CAV_VID_EOS && b == TAG_VERIFIER) begin
            role  = ROLE_TAG;
            start = 1'b1; start_kind = FK_VERIFIER;
          end else begin
            role = ROLE_SECTION_END;
            if (b == SECTION_END) begin
              if (cav_cnt != CAV_MAX) cav_cnt_next = cav_cnt + 1'b1;
              phase_next = PH_CAV_FIRST;
            end else begin
              error_next = 1'b1;
            end
          end
        end
        PH_SIG_TAG: begin
          role = ROLE_TAG;
          if (b == TAG_SIGNATURE) begin
            start = 1'b1; start_kind = FK_SIGNATURE;
          end else begin
            error_next = 1'b1;
          end
        end
        PH_LEN: begin
          role = ROLE_LENGTH;
          kind = cur_field;
          flen = len_acc;
          if (len_ovf) begin
            error_next = 1'b1;
          end else begin
            len_acc_next = acc_or;
            flen         = acc_or;
            if (b[7]) begin
              if (vshift == LAST_SHIFT) error_next = 1'b1;
              else vshift_next = vshift + 1'b1;
            end else begin
              remaining_next = acc_or;
              if (acc_or == '0) fdone = 1'b1;
              else phase_next = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          role           = ROLE_PAYLOAD;
          kind           = cur_field;
          flen           = len_acc;
          off            = len_acc - remaining;
          remaining_next = remaining - 1'b1;
          if (remaining == LEN_BITS'(1)) fdone = 1'b1;
        end
        default: begin
          // no live phase: treat as a broken stream
          role       = ROLE_IGNORED;
          error_next = 1'b1;
        end
      endcase
    end

    // new field: tag seen, length varint follows
    if (start) begin
      cur_field_next = start_kind;
      len_acc_next   = '0;
      vshift_next    = '0;
      phase_next     = PH_LEN;
    end

    // field complete: pick the next grammar position
    if (fdone) begin
      if (cur_field == FK_SIGNATURE) begin
        phase_next = PH_DONE;
        done_next  = 1'b1;
      end else if (cur_section == SEC_HEADER) begin
        phase_next = (cur_field == FK_LOCATION) ? PH_HDR_ID : PH_HDR_EOS;
      end else if (cur_field == FK_LOCATION) begin
        phase_next = PH_CAV_ID;
      end else if (cur_field == FK_IDENTIFIER) begin
        phase_next = PH_CAV_VID_EOS;
      end else begin
        phase_next = PH_CAV_EOS;
      end
    end

    if (error_next) st = ST_INVALID;
    else if (done_next) st = ST_ACCEPTED;
    else st = ST_PROGRESS;
    // message cut short before the signature completed
    if (last && !done_next) st = ST_INVALID;

    res_next.byte_role      = role;
    res_next.field_kind     = kind;
    res_next.section        = cur_section;
    res_next.caveat_index   = cav_cnt_next;
    res_next.field_length   = flen;
    res_next.payload_offset = off;
    res_next.data_out       = b;
    res_next.status         = st;
    res_next.message_end    = last;

    // end of message: back to the reset state for the next one
    if (last) begin
      phase_next       = PH_VER;
      cur_field_next   = FK_LOCATION;
      cur_section_next = SEC_HEADER;
      len_acc_next     = '0;
      vshift_next      = '0;
      remaining_next   = '0;
      cav_cnt_next     = '0;
      error_next       = 1'b0;
      done_next        = 1'b0;
    end
  end

  // handshake: ready while the skid entry is free
  assign byte_in.ready = !skid_valid;
  assign accept        = byte_in.valid && !skid_valid;
  assign out_fire      = out_valid && result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_VER;
      cur_field   <= FK_LOCATION;
      cur_section <= SEC_HEADER;
      len_acc     <= '0;
      vshift      <= '0;
      remaining   <= '0;
      cav_cnt     <= '0;
      error_flag  <= 1'b0;
      done_flag   <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      cur_field   <= cur_field_next;
      cur_section <= cur_section_next;
      len_acc     <= len_acc_next;
      vshift      <= vshift_next;
      remaining   <= remaining_next;
      cav_cnt     <= cav_cnt_next;
      error_flag  <= error_next;
      done_flag   <= done_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (out_valid && !result_out.ready) begin
        skid_q     <= res_next;
        skid_valid <= 1'b1;
      end else begin
        out_q     <= res_next;
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid) begin
        out_q      <= skid_q;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.byte_role      = out_q.byte_role;
  assign result_out.field_kind     = out_q.field_kind;
  assign result_out.section        = out_q.section;
  assign result_out.caveat_index   = out_q.caveat_index;
  assign result_out.field_length   = out_q.field_length;
  assign result_out.payload_offset = out_q.payload_offset;
  assign result_out.data_out       = out_q.data_out;
  assign result_out.status         = out_q.status;
  assign result_out.message_end    = out_q.message_end;

  // skid entry only fills behind a held output register
  `TLVCSP_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // a closing byte leaves the grammar at its start
  `TLVCSP_ASSERT_NXT(a_last_restarts, clk, rst, accept && byte_in.last_byte, phase == PH_VER && !error_flag && !done_flag && cav_cnt == '0)
  // an accepted message never carries an error
  `TLVCSP_ASSERT_IMP(a_flags_exclusive, clk, rst, error_flag, !done_flag)
  // varint byte count stays within the length width
  `TLVCSP_ASSERT_IMP(a_shift_bound, clk, rst, 1'b1, vshift <= LAST_SHIFT)

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the credential stream parser: a directed table of
// bytes, then random messages (mostly well formed, some corrupted, truncated,
// with a bad length or pure noise) under several idling patterns; every result
// transaction is compared field by field with an in-bench grammar predictor
// ---------------------------------------------------------------------------
module tb_top;
  import tlvcsp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 8;

  // grammar position of the predictor
  typedef enum logic [3:0] {
    G_VERSION, G_HDR_FIRST, G_HDR_ID, G_HDR_EOS, G_CAV_FIRST, G_CAV_ID,
    G_CAV_VID_EOS, G_CAV_EOS, G_SIG_TAG, G_LENGTH, G_PAYLOAD, G_DONE
  } gram_phase_t;

  // one byte to send; where marked, role and status are typed in by hand
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    role_t      role;
    status_t    status;
  } byte_stim_t;

  logic clk;
  logic rst;

  tlvcsp_in_if  in_if ();
  tlvcsp_out_if out_if ();

  tlv_credential_stream_parser_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (in_if),
    .result_out (out_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // idling knobs, in percent of cycles
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  int unsigned mismatches;
  int unsigned idle_cycles;

  byte_stim_t sent_bytes[$];      // bytes presented, popped on acceptance
  result_t    pending_results[$]; // predicted results not yet seen

  // predictor state
  gram_phase_t                  gram_phase;
  field_kind_t                  cur_kind;
  logic [63:0]                  len_acc;
  int unsigned                  len_groups;
  logic [63:0]                  left_bytes;
  logic [CAVEAT_COUNT_BITS-1:0] caveats_done;
  bit                           msg_bad;
  bit                           msg_done;
  section_t                     cur_sect;

  function automatic void clear_grammar();
    gram_phase   = G_VERSION;
    cur_kind     = FK_LOCATION;
    len_acc      = '0;
    len_groups   = 0;
    left_bytes   = '0;
    caveats_done = '0;
    msg_bad      = 1'b0;
    msg_done     = 1'b0;
    cur_sect     = SEC_HEADER;
  endfunction

  function automatic void open_field(field_kind_t k);
    cur_kind   = k;
    len_acc    = '0;
    len_groups = 0;
    gram_phase = G_LENGTH;
  endfunction

  function automatic void close_caveat();
    if (caveats_done != '1) caveats_done = caveats_done + 1'b1;
    gram_phase = G_CAV_FIRST;
  endfunction

  // where the grammar goes once a field's payload is complete
  function automatic void close_field();
    if (cur_kind == FK_SIGNATURE) begin
      gram_phase = G_DONE;
      msg_done   = 1'b1;
    end else if (cur_sect == SEC_HEADER) begin
      gram_phase = (cur_kind == FK_LOCATION) ? G_HDR_ID : G_HDR_EOS;
    end else if (cur_kind == FK_LOCATION) begin
      gram_phase = G_CAV_ID;
    end else if (cur_kind == FK_IDENTIFIER) begin
      gram_phase = G_CAV_VID_EOS;
    end else begin
      gram_phase = G_CAV_EOS;
    end
  endfunction

  // result of one accepted byte, advancing the predictor state
  function automatic result_t predict_result(logic [7:0] b, logic last);
    result_t     r;
    int unsigned pos;
    int unsigned room;
    logic [63:0] grp;
    r              = '0;
    r.byte_role    = ROLE_VERSION;
    r.field_kind   = FK_LOCATION;
    r.section      = cur_sect;
    r.data_out     = b;
    r.message_end  = last;
    if (msg_bad) begin
      r.byte_role = ROLE_IGNORED;
    end else if (msg_done) begin
      r.byte_role = ROLE_TRAILING;
    end else begin
      case (gram_phase)
        G_VERSION: begin
          r.byte_role = ROLE_VERSION;
          if (b == VERSION_BYTE) gram_phase = G_HDR_FIRST;
          else msg_bad = 1'b1;
        end
        G_HDR_FIRST: begin
          r.byte_role = ROLE_TAG;
          if (b == TAG_LOCATION) open_field(FK_LOCATION);
          else if (b == TAG_IDENTIFIER) open_field(FK_IDENTIFIER);
          else msg_bad = 1'b1;
        end
        G_HDR_ID, G_CAV_ID: begin
          r.byte_role = ROLE_TAG;
          if (b == TAG_IDENTIFIER) open_field(FK_IDENTIFIER);
          else msg_bad = 1'b1;
        end
        G_HDR_EOS: begin
          r.byte_role = ROLE_SECTION_END;
          if (b == SECTION_END) begin
            cur_sect   = SEC_CAVEATS;
            gram_phase = G_CAV_FIRST;
          end else begin
            msg_bad = 1'b1;
          end
        end
        G_CAV_FIRST: begin
          if (b == SECTION_END) begin
            r.byte_role = ROLE_SECTION_END;
            cur_sect    = SEC_SIGNATURE;
            gram_phase  = G_SIG_TAG;
          end else begin
            r.byte_role = ROLE_TAG;
            if (b == TAG_LOCATION) open_field(FK_LOCATION);
            else if (b == TAG_IDENTIFIER) open_field(FK_IDENTIFIER);
            else msg_bad = 1'b1;
          end
        end
        G_CAV_VID_EOS: begin
          if (b == TAG_VERIFIER) begin
            r.byte_role = ROLE_TAG;
            open_field(FK_VERIFIER);
          end else begin
            r.byte_role = ROLE_SECTION_END;
            if (b == SECTION_END) close_caveat();
            else msg_bad = 1'b1;
          end
        end
        G_CAV_EOS: begin
          r.byte_role = ROLE_SECTION_END;
          if (b == SECTION_END) close_caveat();
          else msg_bad = 1'b1;
        end
        G_SIG_TAG: begin
          r.byte_role = ROLE_TAG;
          if (b == TAG_SIGNATURE) open_field(FK_SIGNATURE);
          else msg_bad = 1'b1;
        end
        G_LENGTH: begin
          r.byte_role  = ROLE_LENGTH;
          r.field_kind = cur_kind;
          pos  = VARINT_BITS * len_groups;
          room = LEN_BITS - pos;
          grp  = {57'd0, b[6:0]};
          if (room < VARINT_BITS && (grp >> room) != 0) begin
            msg_bad = 1'b1;
          end else begin
            len_acc = len_acc | (grp << pos);
            if (b[7]) begin
              if (len_groups + 1 >= MAX_BYTES) msg_bad = 1'b1;
              else len_groups++;
            end else begin
              left_bytes = len_acc;
              if (len_acc == 0) close_field();
              else gram_phase = G_PAYLOAD;
            end
          end
          r.field_length = len_acc[LEN_BITS-1:0];
        end
        G_PAYLOAD: begin
          r.byte_role      = ROLE_PAYLOAD;
          r.field_kind     = cur_kind;
          r.field_length   = len_acc[LEN_BITS-1:0];
          r.payload_offset = LEN_BITS'(len_acc - left_bytes);
          left_bytes       = left_bytes - 1;
          if (left_bytes == 0) close_field();
        end
        default: begin
          r.byte_role = ROLE_IGNORED;
          msg_bad     = 1'b1;
        end
      endcase
    end
    r.caveat_index = caveats_done;
    if (msg_bad) r.status = ST_INVALID;
    else if (msg_done) r.status = ST_ACCEPTED;
    else r.status = ST_PROGRESS;
    if (last && !msg_done) r.status = ST_INVALID;
    if (last) clear_grammar();
    return r;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // receiver: stalls at random according to the current knob
  always @(posedge clk) begin
    if (rst) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: checks result transactions, predicts on byte transactions
  always @(posedge clk) begin
    result_t    got;
    result_t    want;
    byte_stim_t row;
    if (!rst) begin
      if (out_if.valid && out_if.ready) begin
        got.byte_role      = out_if.byte_role;
        got.field_kind     = out_if.field_kind;
        got.section        = out_if.section;
        got.caveat_index   = out_if.caveat_index;
        got.field_length   = out_if.field_length;
        got.payload_offset = out_if.payload_offset;
        got.data_out       = out_if.data_out;
        got.status         = out_if.status;
        got.message_end    = out_if.message_end;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing expected, actual data_out 0x%0h role %0d",
                   $time, got.data_out, got.byte_role);
        end else begin
          want = pending_results.pop_front();
          compare_field("byte_role", 64'(want.byte_role), 64'(got.byte_role));
          compare_field("field_kind", 64'(want.field_kind), 64'(got.field_kind));
          compare_field("section", 64'(want.section), 64'(got.section));
          compare_field("caveat_index", 64'(want.caveat_index), 64'(got.caveat_index));
          compare_field("field_length", 64'(want.field_length), 64'(got.field_length));
          compare_field("payload_offset", 64'(want.payload_offset),
                        64'(got.payload_offset));
          compare_field("data_out", 64'(want.data_out), 64'(got.data_out));
          compare_field("status", 64'(want.status), 64'(got.status));
          compare_field("message_end", 64'(want.message_end), 64'(got.message_end));
        end
      end
      if (in_if.valid && in_if.ready) begin
        row  = sent_bytes.pop_front();
        want = predict_result(in_if.data_byte, in_if.last_byte);
        // hand-typed rows override role and status with the table's values
        if (row.typed) begin
          want.byte_role = row.role;
          want.status    = row.status;
        end
        pending_results.push_back(want);
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one byte, with random idle cycles first, and wait for the handshake
  task automatic send_byte(input byte_stim_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= s.data;
    in_if.last_byte <= s.last;
    sent_bytes.push_back(s);
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_message(input logic [7:0] m[$]);
    byte_stim_t s;
    s.typed  = 1'b0;
    s.role   = ROLE_VERSION;
    s.status = ST_PROGRESS;
    foreach (m[i]) begin
      s.data = m[i];
      s.last = (i == m.size() - 1);
      send_byte(s);
    end
  endtask

  // sender holds off until every predicted result has been taken
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // little-endian base-128 length, now and then padded to a non-minimal form
  function automatic void put_varint(ref logic [7:0] m[$], input logic [31:0] len);
    int unsigned n;
    int unsigned total;
    logic [63:0] grp;
    n = 1;
    while (n < MAX_BYTES && ({32'd0, len} >> (VARINT_BITS * n)) != 0) n++;
    total = n;
    if ($urandom_range(7) == 0) total = n + $urandom_range(MAX_BYTES - n);
    for (int unsigned i = 0; i < total; i++) begin
      grp = ({32'd0, len} >> (VARINT_BITS * i)) & 64'h7f;
      m.push_back({(i < total - 1) ? 1'b1 : 1'b0, grp[6:0]});
    end
  endfunction

  function automatic void put_field(ref logic [7:0] m[$], input logic [7:0] tag);
    logic [31:0] len;
    len = ($urandom_range(15) == 0) ? $urandom_range(200) : $urandom_range(4);
    m.push_back(tag);
    put_varint(m, len);
    repeat (len) m.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void build_good_message(ref logic [7:0] m[$]);
    int unsigned ncav;
    m.delete();
    m.push_back(VERSION_BYTE);
    if ($urandom_range(1)) put_field(m, TAG_LOCATION);
    put_field(m, TAG_IDENTIFIER);
    m.push_back(SECTION_END);
    ncav = $urandom_range(3);
    repeat (ncav) begin
      if ($urandom_range(1)) put_field(m, TAG_LOCATION);
      put_field(m, TAG_IDENTIFIER);
      if ($urandom_range(1)) put_field(m, TAG_VERIFIER);
      m.push_back(SECTION_END);
    end
    m.push_back(SECTION_END);
    put_field(m, TAG_SIGNATURE);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) m.push_back(8'($urandom_range(255)));
    end
  endfunction

  // an identifier whose length is too long, too wide, or huge and cut short
  function automatic void build_bad_length(ref logic [7:0] m[$]);
    logic [31:0] len;
    m.delete();
    m.push_back(VERSION_BYTE);
    m.push_back(TAG_IDENTIFIER);
    case ($urandom_range(2))
      0: begin
        repeat (MAX_BYTES - 1) m.push_back(8'hff);
        m.push_back(8'h80 | 8'($urandom_range(127)));
      end
      1: begin
        repeat (MAX_BYTES - 1) m.push_back(8'h80 | 8'($urandom_range(127)));
        m.push_back(8'($urandom_range(16, 127)));
      end
      default: begin
        len = $urandom() | 32'h8000_0000;
        put_varint(m, len);
        repeat ($urandom_range(1, 5)) m.push_back(8'($urandom_range(255)));
      end
    endcase
    repeat ($urandom_range(2)) m.push_back(8'($urandom_range(255)));
  endfunction

  // random messages until about n_items meaningful bytes have gone in
  task automatic run_random(input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned n_items);
    logic [7:0]  m[$];
    int unsigned sent;
    int unsigned pick;
    int unsigned idx;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 88) begin
        build_good_message(m);
        if (pick >= 70 && pick < 80) begin
          // one byte replaced by a random one
          idx    = $urandom_range(m.size() - 1);
          m[idx] = 8'($urandom_range(255));
        end else if (pick >= 80) begin
          // short message: cut anywhere before the end
          idx = $urandom_range(1, m.size() - 1);
          while (m.size() > idx) void'(m.pop_back());
        end
        sent += m.size();
      end else if (pick < 94) begin
        build_bad_length(m);
        sent += m.size();
      end else begin
        m.delete();
        repeat ($urandom_range(1, 8)) m.push_back(8'($urandom_range(255)));
      end
      send_message(m);
    end
    drain_results();
  endtask

  // directed table: accepted message with zero-length and non-minimal
  // lengths, verifier id and a trailing byte; wrong version; message cut
  // after the version; length varint one group too long
  byte_stim_t directed_rows[29];

  initial begin
    directed_rows = '{
      '{8'h02, 1'b0, 1'b1, ROLE_VERSION,     ST_PROGRESS},
      '{8'h01, 1'b0, 1'b1, ROLE_TAG,         ST_PROGRESS},
      '{8'h00, 1'b0, 1'b1, ROLE_LENGTH,      ST_PROGRESS},
      '{8'h02, 1'b0, 1'b1, ROLE_TAG,         ST_PROGRESS},
      '{8'h01, 1'b0, 1'b1, ROLE_LENGTH,      ST_PROGRESS},
      '{8'hff, 1'b0, 1'b1, ROLE_PAYLOAD,     ST_PROGRESS},
      '{8'h00, 1'b0, 1'b1, ROLE_SECTION_END, ST_PROGRESS},
      '{8'h02, 1'b0, 1'b0, ROLE_VERSION,     ST_PROGRESS},
      '{8'h80, 1'b0, 1'b0, ROLE_VERSION,     ST_PROGRESS},
      '{8'h00, 1'b0, 1'b0, ROLE_VERSION,     ST_PROGRESS},
      '{8'h04, 1'b0, 1'b0, ROLE_VERSION,     ST_PROGRESS},
      '{8'h00, 1'b0, 1'b0, ROLE_VERSION,     ST_PROGRESS},
      '{8'h00, 1'b0, 1'b1, ROLE_SECTION_END, ST_PROGRESS},
      '{8'h00, 1'b0, 1'b1, ROLE_SECTION_END, ST_PROGRESS},
      '{8'h06, 1'b0, 1'b1, ROLE_TAG,         ST_PROGRESS},
      '{8'h01, 1'b0, 1'b0, ROLE_VERSION,     ST_PROGRESS},
      '{8'h7f, 1'b0, 1'b1, ROLE_PAYLOAD,     ST_ACCEPTED},
      '{8'haa, 1'b1, 1'b1, ROLE_TRAILING,    ST_ACCEPTED},
      '{8'h03, 1'b0, 1'b1, ROLE_VERSION,     ST_INVALID},
      '{8'h00, 1'b1, 1'b1, ROLE_IGNORED,     ST_INVALID},
      '{8'h02, 1'b1, 1'b1, ROLE_VERSION,     ST_INVALID},
      '{8'h02, 1'b0, 1'b0, ROLE_VERSION,     ST_PROGRESS},
      '{8'h02, 1'b0, 1'b0, ROLE_VERSION,     ST_PROGRESS},
      '{8'hff, 1'b0, 1'b0, ROLE_VERSION,     ST_PROGRESS},
      '{8'hff, 1'b0, 1'b0, ROLE_VERSION,     ST_PROGRESS},
      '{8'hff, 1'b0, 1'b0, ROLE_VERSION,     ST_PROGRESS},
      '{8'hff, 1'b0, 1'b0, ROLE_VERSION,     ST_PROGRESS},
      '{8'h8f, 1'b0, 1'b1, ROLE_LENGTH,      ST_INVALID},
      '{8'h00, 1'b1, 1'b1, ROLE_IGNORED,     ST_INVALID}
    };

    mismatches      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    clear_grammar();
    rst              = 1'b1;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= 8'h00;
    in_if.last_byte <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_byte(directed_rows[i]);
    drain_results();

    // random phases, each ending with the sender held until all results are in
    run_random(0, 0, 360);
    run_random(83, 0, 360);
    run_random(0, 83, 360);
    run_random(31, 31, 370);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
